// ===== rtl/tgce_pkg.sv =====
// shared types and constants of the toffoli gate cnf encoder
package tgce_pkg;

    localparam int MAX_WIRES    = 256;
    localparam int MAX_CONTROLS = 7;
    localparam int WIRE_W       = 8;
    localparam int WCNT_W       = WIRE_W + 1;
    localparam int VAR_W        = 32;
    localparam int HELD_W       = $clog2(MAX_CONTROLS + 1);
    localparam int IDX_W        = $clog2(MAX_CONTROLS);
    localparam int LWIDTH_W     = 7;

    localparam logic [VAR_W:0] VAR_LIMIT = (VAR_W + 1)'(32'h7FFF_FFFF);

    localparam logic [1:0] KIND_CTRL   = 2'd0;
    localparam logic [1:0] KIND_TARGET = 2'd1;
    localparam logic [1:0] KIND_QUERY  = 2'd2;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_CTRL_CNT  = 3'd1;
    localparam logic [2:0] ERR_WIRE      = 3'd2;
    localparam logic [2:0] ERR_DUP       = 3'd3;
    localparam logic [2:0] ERR_EXHAUSTED = 3'd4;

    typedef struct packed {
        logic [1:0]        kind;
        logic [WIRE_W-1:0] wire_req;
        logic              flag;
    } t_req;

    typedef struct packed {
        logic signed [VAR_W-1:0] literal;
        logic                    clause_end;
        logic                    last;
        logic [2:0]              error;
    } t_res;

    typedef struct packed {
        logic              we;
        logic [WIRE_W-1:0] addr;
        logic [VAR_W-1:0]  data;
    } t_map_wr;

endpackage

// ===== rtl/tgce_var_map.sv =====
// wire to sat variable map with per-entry valid bits and reset value wire plus one
module tgce_var_map (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  tgce_pkg::t_map_wr           i_wr,
    input  logic [tgce_pkg::WIRE_W-1:0] i_raddr,
    output logic [tgce_pkg::VAR_W-1:0]  o_rdata
);

    logic [tgce_pkg::VAR_W-1:0]  r_mem [tgce_pkg::MAX_WIRES];
    logic [tgce_pkg::MAX_WIRES-1:0] r_valid;
    logic [tgce_pkg::VAR_W-1:0]  r_rdata;
    logic                        r_rvalid;
    logic [tgce_pkg::WIRE_W-1:0] r_raddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.we) begin
            r_valid[i_wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rdata  <= r_mem[i_raddr];
        r_rvalid <= r_valid[i_raddr];
        r_raddr  <= i_raddr;
    end

    assign o_rdata = r_rvalid ? r_rdata
                   : tgce_pkg::VAR_W'(r_raddr) + tgce_pkg::VAR_W'(1);

endmodule

// ===== rtl/toffoli_gate_cnf_encoder_unit.sv =====
// top level of the toffoli gate cnf encoder: sequencer, control buffer and literal emitter
//
// Each request is taken when start is high and busy is low; busy then stays high until
// the request is done. Results leave one per cycle on o_res, each marked by o_res_strobe
// for a single cycle, and the receiver cannot stall them. A control or a target first runs
// the duplicate scan, which uses one comparator over the control buffer of held controls,
// and a query reads the wire map. A target then emits its clauses, one literal a cycle
// through the shared negate unit. A request that fails its range or count check, and a
// target of a faulty gate, end in the check state. The wire map read has a registered port.
// logical_width is written on the cfg channel, which is ready whenever busy is low.
module toffoli_gate_cnf_encoder_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tgce_pkg::t_req                i_req,
    output logic                          o_res_strobe,
    output tgce_pkg::t_res                o_res,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [tgce_pkg::LWIDTH_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EVAL = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    localparam logic [1:0] SEC_PAIRS = 2'd0;
    localparam logic [1:0] SEC_POS   = 2'd1;
    localparam logic [1:0] SEC_NEG   = 2'd2;

    logic [2:0]                          r_state;
    logic [tgce_pkg::LWIDTH_W-1:0]       r_lwidth;
    tgce_pkg::t_req                      r_req;
    logic [tgce_pkg::VAR_W-1:0]          r_gates;
    logic [tgce_pkg::HELD_W-1:0]         r_held;
    logic                                r_faulty;
    logic [tgce_pkg::IDX_W-1:0]          r_idx;
    logic [2:0]                          r_sub;
    logic [1:0]                          r_sec;
    logic [tgce_pkg::VAR_W:0]            r_nv;
    logic [tgce_pkg::VAR_W-1:0]          r_old;
    logic [tgce_pkg::VAR_W-1:0]          r_newlit;
    logic [tgce_pkg::VAR_W-1:0]          r_clit [tgce_pkg::MAX_CONTROLS];
    logic [tgce_pkg::WIRE_W-1:0]         r_cwire [tgce_pkg::MAX_CONTROLS];
    logic                                r_strobe;
    tgce_pkg::t_res                      r_res;

    logic [tgce_pkg::WCNT_W-1:0]         wires;
    logic [tgce_pkg::WCNT_W-1:0]         wires_raw;
    logic                                wire_bad;
    logic [tgce_pkg::VAR_W-1:0]          map_rdata;
    tgce_pkg::t_map_wr                   map_wr;
    logic [tgce_pkg::VAR_W-1:0]          sel_x;
    logic                                sel_neg;
    logic                                sel_end;
    logic                                sel_last;
    logic [tgce_pkg::VAR_W-1:0]          sel_lit;
    logic [tgce_pkg::VAR_W-1:0]          map_lit;

    assign wires_raw = {r_lwidth, 2'b00};
    assign wires     = (wires_raw > tgce_pkg::WCNT_W'(tgce_pkg::MAX_WIRES))
                     ? tgce_pkg::WCNT_W'(tgce_pkg::MAX_WIRES) : wires_raw;
    assign wire_bad  = {1'b0, r_req.wire_req} >= wires;

    assign busy        = r_state != S_IDLE;
    assign o_cfg_ready = !busy;

    assign map_wr.we   = (r_state == S_EMIT) && sel_last;
    assign map_wr.addr = r_req.wire_req;
    assign map_wr.data = r_nv[tgce_pkg::VAR_W-1:0];

    tgce_var_map u_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (map_wr),
        .i_raddr (r_req.wire_req),
        .o_rdata (map_rdata)
    );

    assign map_lit = r_req.flag ? map_rdata : tgce_pkg::VAR_W'(0) - map_rdata;

    // shared literal unit: pick an operand, negate it where needed and mark clause ends
    always_comb begin
        sel_x    = r_old;
        sel_neg  = 1'b0;
        sel_end  = 1'b0;
        sel_last = 1'b0;
        case (r_sec)
            SEC_PAIRS: begin
                case (r_sub) inside
                    3'd0, 3'd3: sel_x = r_clit[r_idx];
                    3'd1: begin
                        sel_x   = r_old;
                        sel_neg = 1'b1;
                    end
                    3'd4: sel_x = r_old;
                    3'd2: begin
                        sel_x   = r_newlit;
                        sel_end = 1'b1;
                    end
                    default: begin
                        sel_x   = r_newlit;
                        sel_neg = 1'b1;
                        sel_end = 1'b1;
                    end
                endcase
            end
            default: begin
                if (tgce_pkg::HELD_W'(r_idx) < r_held) begin
                    sel_x   = r_clit[r_idx];
                    sel_neg = 1'b1;
                end else begin
                    sel_x    = (r_sub == 3'd0) ? r_old : r_newlit;
                    sel_neg  = r_sec == SEC_NEG;
                    sel_end  = r_sub != 3'd0;
                    sel_last = (r_sub != 3'd0) && (r_sec == SEC_NEG);
                end
            end
        endcase
        sel_lit = sel_neg ? tgce_pkg::VAR_W'(0) - sel_x : sel_x;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_lwidth <= tgce_pkg::LWIDTH_W'(1);
            r_gates  <= '0;
            r_held   <= '0;
            r_faulty <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            if (i_cfg_valid && o_cfg_ready) begin
                r_lwidth <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_req   <= i_req;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_idx   <= '0;
                    r_sub   <= '0;
                    r_nv    <= (tgce_pkg::VAR_W + 1)'(wires)
                             + {1'b0, r_gates} + (tgce_pkg::VAR_W + 1)'(1);
                    r_res.literal    <= '0;
                    r_res.clause_end <= 1'b0;
                    r_res.last       <= 1'b1;
                    r_state          <= S_IDLE;
                    case (r_req.kind)
                        tgce_pkg::KIND_CTRL: begin
                            if (wire_bad) begin
                                r_faulty    <= 1'b1;
                                r_strobe    <= 1'b1;
                                r_res.error <= tgce_pkg::ERR_WIRE;
                            end else if (r_held >= tgce_pkg::HELD_W'(tgce_pkg::MAX_CONTROLS))
                            begin
                                r_faulty    <= 1'b1;
                                r_strobe    <= 1'b1;
                                r_res.error <= tgce_pkg::ERR_CTRL_CNT;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                        tgce_pkg::KIND_TARGET: begin
                            if (r_faulty) begin
                                r_held   <= '0;
                                r_faulty <= 1'b0;
                            end else if (wire_bad) begin
                                r_held      <= '0;
                                r_strobe    <= 1'b1;
                                r_res.error <= tgce_pkg::ERR_WIRE;
                            end else begin
                                r_state <= S_SCAN;
                            end
                        end
                        tgce_pkg::KIND_QUERY: begin
                            if (wire_bad) begin
                                r_strobe    <= 1'b1;
                                r_res.error <= tgce_pkg::ERR_WIRE;
                            end else begin
                                r_state <= S_READ;
                            end
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                S_SCAN: begin
                    if (tgce_pkg::HELD_W'(r_idx) == r_held) begin
                        r_state <= S_READ;
                    end else if (r_cwire[r_idx] == r_req.wire_req) begin
                        r_strobe    <= 1'b1;
                        r_res.error <= tgce_pkg::ERR_DUP;
                        r_state     <= S_IDLE;
                        if (r_req.kind == tgce_pkg::KIND_CTRL) begin
                            r_faulty <= 1'b1;
                        end else begin
                            r_held   <= '0;
                            r_faulty <= 1'b0;
                        end
                    end else begin
                        r_idx <= r_idx + tgce_pkg::IDX_W'(1);
                    end
                end
                S_READ: begin
                    r_idx   <= '0;
                    r_sub   <= '0;
                    r_state <= S_IDLE;
                    if (r_req.kind == tgce_pkg::KIND_CTRL) begin
                        r_cwire[r_held[tgce_pkg::IDX_W-1:0]] <= r_req.wire_req;
                        r_clit[r_held[tgce_pkg::IDX_W-1:0]]  <= map_lit;
                        r_held <= r_held + tgce_pkg::HELD_W'(1);
                    end else if (r_req.kind == tgce_pkg::KIND_QUERY) begin
                        r_strobe         <= 1'b1;
                        r_res.literal    <= map_lit;
                        r_res.clause_end <= 1'b1;
                        r_res.last       <= 1'b1;
                        r_res.error      <= tgce_pkg::ERR_OK;
                    end else if (r_nv > tgce_pkg::VAR_LIMIT) begin
                        r_held      <= '0;
                        r_strobe    <= 1'b1;
                        r_res.error <= tgce_pkg::ERR_EXHAUSTED;
                    end else begin
                        r_old    <= map_rdata;
                        r_newlit <= r_req.flag
                                  ? tgce_pkg::VAR_W'(0) - r_nv[tgce_pkg::VAR_W-1:0]
                                  : r_nv[tgce_pkg::VAR_W-1:0];
                        r_sec    <= (r_held == '0) ? SEC_POS : SEC_PAIRS;
                        r_state  <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    r_strobe         <= 1'b1;
                    r_res.literal    <= sel_lit;
                    r_res.clause_end <= sel_end;
                    r_res.last       <= sel_last;
                    r_res.error      <= tgce_pkg::ERR_OK;
                    if (r_sec == SEC_PAIRS) begin
                        if (r_sub == 3'd5) begin
                            r_sub <= '0;
                            if (tgce_pkg::HELD_W'(r_idx) + tgce_pkg::HELD_W'(1) == r_held)
                            begin
                                r_idx <= '0;
                                r_sec <= SEC_POS;
                            end else begin
                                r_idx <= r_idx + tgce_pkg::IDX_W'(1);
                            end
                        end else begin
                            r_sub <= r_sub + 3'd1;
                        end
                    end else if (tgce_pkg::HELD_W'(r_idx) < r_held) begin
                        r_idx <= r_idx + tgce_pkg::IDX_W'(1);
                    end else if (r_sub == 3'd0) begin
                        r_sub <= 3'd1;
                    end else if (r_sec == SEC_POS) begin
                        r_sub <= '0;
                        r_idx <= '0;
                        r_sec <= SEC_NEG;
                    end else begin
                        r_gates  <= r_gates + tgce_pkg::VAR_W'(1);
                        r_held   <= '0;
                        r_faulty <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res_strobe = r_strobe;
    assign o_res        = r_res;

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.error != tgce_pkg::ERR_OK) |-> o_res.last)
        else $error("error result without last mark");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_held <= tgce_pkg::HELD_W'(tgce_pkg::MAX_CONTROLS))
        else $error("control buffer overfilled");

    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted without going busy");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_strobe && o_res.last) |=> !o_res_strobe)
        else $error("result directly after final result");

    a_map_write_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        map_wr.we |=> (o_res_strobe && o_res.last && o_res.clause_end))
        else $error("map written outside final clause");

endmodule
